### src/cbd_pkg.sv
package cbd_pkg;

	// Decoder phases, as shown on the phase output
	localparam logic [2:0] PH_SIZE    = 3'd0;
	localparam logic [2:0] PH_DATA    = 3'd1;
	localparam logic [2:0] PH_CRLF    = 3'd2;
	localparam logic [2:0] PH_TRAILER = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;
	localparam logic [2:0] PH_ERROR   = 3'd5;

	// Size line sub-phases
	localparam logic [1:0] SUB_DIGITS = 2'd0;
	localparam logic [1:0] SUB_ENDED  = 2'd1;
	localparam logic [1:0] SUB_BAD    = 2'd2;

	// Byte codes
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_NUL  = 8'h00;

	localparam logic [3:0] MAX_DIGITS = 4'd8;

	// Decoder state
	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  line_count;
		logic [31:0] size_accum;
		logic [3:0]  sig_count;
		logic        digit_seen;
		logic [1:0]  sub_phase;
		logic [31:0] remaining;
		logic [31:0] total_count;
		logic        trailer_nonblank;
	} state_t;

	// One result beat
	typedef struct packed {
		logic        consumed;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [2:0]  phase;
		logic [31:0] chunk_left;
		logic [31:0] body_total;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:            PH_SIZE,
		line_count:       8'd0,
		size_accum:       32'd0,
		sig_count:        4'd0,
		digit_seen:       1'b0,
		sub_phase:        SUB_DIGITS,
		remaining:        32'd0,
		total_count:      32'd0,
		trailer_nonblank: 1'b0
	};

	// Hex digit decode: {is_digit, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

### src/cbd_step.sv
module cbd_step #(
	parameter int LINE_BYTES = 64
) (
	input  logic [7:0]       data_byte,
	input  logic             body_start,
	input  cbd_pkg::state_t  cur,
	output cbd_pkg::state_t  nxt,
	output cbd_pkg::result_t res
);

	localparam logic [8:0] LineLimit = 9'(LINE_BYTES);

	cbd_pkg::state_t st;
	logic [4:0]      hx;
	logic [3:0]      sig_inc;
	logic            consumed;
	logic            pvalid;
	logic [31:0]     rem_dec;

	assign hx      = cbd_pkg::hex_decode(data_byte);
	assign rem_dec = st.remaining - 32'd1;

	always_comb begin
		st       = body_start ? cbd_pkg::STATE_RESET : cur;
		nxt      = st;
		consumed = 1'b1;
		pvalid   = 1'b0;
		sig_inc  = st.sig_count + {3'd0, (st.sig_count != 4'd0) || (hx[3:0] != 4'd0)};

		unique case (st.phase)
			cbd_pkg::PH_SIZE: begin
				if (data_byte == cbd_pkg::CH_CR) begin
					// dropped
				end else if (data_byte == cbd_pkg::CH_LF) begin
					if (st.sub_phase == cbd_pkg::SUB_BAD || !st.digit_seen) begin
						nxt.phase = cbd_pkg::PH_ERROR;
					end else begin
						nxt.remaining        = st.size_accum;
						nxt.trailer_nonblank = 1'b0;
						nxt.phase = (st.size_accum != 32'd0) ? cbd_pkg::PH_DATA
						                                     : cbd_pkg::PH_TRAILER;
					end
					nxt.line_count = 8'd0;
					nxt.size_accum = 32'd0;
					nxt.sig_count  = 4'd0;
					nxt.digit_seen = 1'b0;
					nxt.sub_phase  = cbd_pkg::SUB_DIGITS;
				end else if ({1'b0, st.line_count} + 9'd1 >= LineLimit) begin
					// line too long
					nxt.phase = cbd_pkg::PH_ERROR;
				end else begin
					nxt.line_count = st.line_count + 8'd1;
					if (st.sub_phase == cbd_pkg::SUB_DIGITS) begin
						if (!hx[4]) begin
							nxt.sub_phase = (data_byte == cbd_pkg::CH_NUL ||
							                 data_byte == cbd_pkg::CH_SEMI)
							              ? cbd_pkg::SUB_ENDED : cbd_pkg::SUB_BAD;
						end else begin
							nxt.sig_count = sig_inc;
							if (sig_inc > cbd_pkg::MAX_DIGITS) begin
								nxt.sub_phase = cbd_pkg::SUB_BAD;
							end else begin
								nxt.size_accum = {st.size_accum[27:0], hx[3:0]};
								nxt.digit_seen = 1'b1;
							end
						end
					end
				end
			end
			cbd_pkg::PH_DATA: begin
				if (st.remaining == 32'd0) begin
					// empty chunk: treat byte as after-data CRLF
					if (data_byte == cbd_pkg::CH_LF) begin
						nxt.phase = cbd_pkg::PH_SIZE;
					end else if (data_byte != cbd_pkg::CH_CR) begin
						nxt.phase = cbd_pkg::PH_ERROR;
					end else begin
						nxt.phase = cbd_pkg::PH_CRLF;
					end
				end else begin
					pvalid          = 1'b1;
					nxt.remaining   = rem_dec;
					nxt.total_count = st.total_count + 32'd1;
					if (rem_dec == 32'd0) begin
						nxt.phase = cbd_pkg::PH_CRLF;
					end
				end
			end
			cbd_pkg::PH_CRLF: begin
				if (data_byte == cbd_pkg::CH_LF) begin
					nxt.phase = cbd_pkg::PH_SIZE;
				end else if (data_byte != cbd_pkg::CH_CR) begin
					nxt.phase = cbd_pkg::PH_ERROR;
				end
			end
			cbd_pkg::PH_TRAILER: begin
				if (data_byte == cbd_pkg::CH_LF) begin
					if (!st.trailer_nonblank) begin
						nxt.phase = cbd_pkg::PH_DONE;
					end
					nxt.trailer_nonblank = 1'b0;
				end else if (data_byte != cbd_pkg::CH_CR) begin
					nxt.trailer_nonblank = 1'b1;
				end
			end
			default: begin
				// done, error and unused codes refuse the byte
				consumed = 1'b0;
			end
		endcase
	end

	assign res.consumed      = consumed;
	assign res.payload_valid = pvalid;
	assign res.payload_byte  = pvalid ? data_byte : 8'd0;
	assign res.phase         = nxt.phase;
	assign res.chunk_left    = nxt.remaining;
	assign res.body_total    = nxt.total_count;

endmodule

### src/chunked_body_decoder.sv
// Chunked body decoder.
// Input channel: one body byte per beat on data_byte, with body_start set on
// the first byte of a new body to clear all decoder state before that byte.
// A beat is taken when data_valid is high and data_stall is low.
// Result channel: one beat per input byte, taken when result_valid is high
// and result_stall is low. It carries consumed, payload_valid/payload_byte,
// the phase after the byte, chunk_left and the wrapping body_total.
// A byte taken sits in the input register and is decoded into the result
// register once that register is free; the result is offered from there.
// Throughput is one byte per cycle while result_stall holds no result; the
// decoder state updates as each byte leaves the input register.
// When result_stall holds a pending result, the input register holds too and
// data_stall rises once it is full; nothing is dropped.
// Reset (arst_n low) empties both registers and puts the decoder in the
// size-line phase with all counts cleared.
// After done or error the block keeps taking beats but reports consumed = 0
// until a byte with body_start arrives.
module chunked_body_decoder #(
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        body_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        consumed,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [2:0]  phase,
	output logic [31:0] chunk_left,
	output logic [31:0] body_total
);

	logic             valid_s1;
	logic [7:0]       data_byte_s1;
	logic             body_start_s1;
	logic             valid_s2;
	cbd_pkg::result_t res_s2;
	cbd_pkg::state_t  state_q;
	cbd_pkg::state_t  state_nxt;
	cbd_pkg::result_t res_nxt;
	logic             out_free;
	logic             adv_s1;
	logic             take_in;

	// Handshake: result register frees when empty or taken
	assign out_free   = !valid_s2 || !result_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign data_stall = valid_s1 && !out_free;
	assign take_in    = data_valid && !data_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_byte_s1  <= data_byte;
			body_start_s1 <= body_start;
		end
	end

	// Step logic
	cbd_step #(
		.LINE_BYTES(LINE_BYTES)
	) u_step (
		.data_byte  (data_byte_s1),
		.body_start (body_start_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbd_pkg::STATE_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid  = valid_s2;
	assign consumed      = res_s2.consumed;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign phase         = res_s2.phase;
	assign chunk_left    = res_s2.chunk_left;
	assign body_total    = res_s2.body_total;

endmodule

### src/cbd_checker.sv
module cbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        consumed,
	input logic        payload_valid,
	input logic [7:0]  payload_byte,
	input logic [2:0]  phase,
	input logic [31:0] chunk_left
);

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(payload_byte))
		else $error("stalled result beat changed");

	// Payload only comes from consumed bytes
	a_pay_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && payload_valid |-> consumed)
		else $error("payload on a refused byte");

	// Payload leaves the decoder in data or after-data phase
	a_pay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && payload_valid |-> phase == cbd_pkg::PH_DATA ||
		                                  phase == cbd_pkg::PH_CRLF)
		else $error("payload with wrong phase");

	// Refused bytes only in done or error
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !consumed |-> phase == cbd_pkg::PH_DONE ||
		                              phase == cbd_pkg::PH_ERROR)
		else $error("byte refused outside done or error");

	// Data phase always has bytes left
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && phase == cbd_pkg::PH_DATA |-> chunk_left != 32'd0)
		else $error("data phase with empty chunk");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.consumed      (consumed),
	.payload_valid (payload_valid),
	.payload_byte  (payload_byte),
	.phase         (phase),
	.chunk_left    (chunk_left)
);

### tb/sv/tb.sv
module tb;

	localparam int LINE_LEN = 64;
	localparam int DRAIN_CYCLES = 6;

	// Ways a random body gets broken
	typedef enum int {
		FLAW_NONE,
		FLAW_FLIP,
		FLAW_CUT,
		FLAW_NINE,
		FLAW_LONG,
		FLAW_HUGE,
		FLAW_NODIGIT
	} flaw_e;

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_stall;
	logic [7:0]  data_byte;
	logic        body_start;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        consumed;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [2:0]  phase;
	logic [31:0] chunk_left;
	logic [31:0] body_total;

	chunked_body_decoder #(
		.LINE_BYTES(LINE_LEN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.body_start   (body_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.consumed     (consumed),
		.payload_valid(payload_valid),
		.payload_byte (payload_byte),
		.phase        (phase),
		.chunk_left   (chunk_left),
		.body_total   (body_total)
	);

	// Decoder state as predicted by the testbench
	logic [2:0]  dec_phase = cbd_pkg::PH_SIZE;
	logic [7:0]  dec_line = '0;
	logic [31:0] dec_accum = '0;
	logic [3:0]  dec_sig = '0;
	logic        dec_digit = 1'b0;
	logic [1:0]  dec_sub = cbd_pkg::SUB_DIGITS;
	logic [31:0] dec_left = '0;
	logic [31:0] dec_total = '0;
	logic        dec_trailer_text = 1'b0;

	cbd_pkg::result_t expected_q[$];
	logic [7:0]  pend_q[$];

	bit          idle_on = 1'b0;
	int          stall_left = 0;
	int          errors = 0;
	int          taken_bytes = 0;
	int          bodies_sent = 0;
	int          payload_seen = 0;
	int          bodies_done = 0;
	int          bodies_failed = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic int hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end
		if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end
		if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return -1;
	endfunction

	function automatic void clear_size_line();
		dec_line = '0;
		dec_accum = '0;
		dec_sig = '0;
		dec_digit = 1'b0;
		dec_sub = cbd_pkg::SUB_DIGITS;
	endfunction

	// CR is tolerated, LF closes the chunk, anything else is fatal
	function automatic void after_data(input logic [7:0] c);
		if (c == cbd_pkg::CH_LF) begin
			dec_phase = cbd_pkg::PH_SIZE;
		end else if (c != cbd_pkg::CH_CR) begin
			dec_phase = cbd_pkg::PH_ERROR;
		end
	endfunction

	function automatic cbd_pkg::result_t decode_byte(input logic [7:0] c, input logic start);
		cbd_pkg::result_t r;
		int d;
		r = '0;
		r.consumed = 1'b1;
		d = hex_val(c);
		if (start) begin
			dec_phase = cbd_pkg::PH_SIZE;
			clear_size_line();
			dec_left = '0;
			dec_total = '0;
			dec_trailer_text = 1'b0;
		end
		case (dec_phase)
			cbd_pkg::PH_SIZE: begin
				if (c == cbd_pkg::CH_LF) begin
					if (dec_sub == cbd_pkg::SUB_BAD || !dec_digit) begin
						dec_phase = cbd_pkg::PH_ERROR;
					end else begin
						dec_left = dec_accum;
						dec_trailer_text = 1'b0;
						dec_phase = (dec_left != 0) ? cbd_pkg::PH_DATA
						                            : cbd_pkg::PH_TRAILER;
					end
					clear_size_line();
				end else if (c != cbd_pkg::CH_CR) begin
					if (int'(dec_line) + 1 >= LINE_LEN) begin
						dec_phase = cbd_pkg::PH_ERROR;
					end else begin
						dec_line = dec_line + 8'd1;
						if (dec_sub == cbd_pkg::SUB_DIGITS) begin
							if (d < 0) begin
								dec_sub = (c == cbd_pkg::CH_NUL || c == cbd_pkg::CH_SEMI)
								        ? cbd_pkg::SUB_ENDED : cbd_pkg::SUB_BAD;
							end else begin
								if (dec_sig != 0 || d != 0) begin
									dec_sig = dec_sig + 4'd1;
								end
								if (dec_sig > cbd_pkg::MAX_DIGITS) begin
									dec_sub = cbd_pkg::SUB_BAD;
								end else begin
									dec_accum = {dec_accum[27:0], 4'(d)};
									dec_digit = 1'b1;
								end
							end
						end
					end
				end
			end
			cbd_pkg::PH_DATA: begin
				if (dec_left == 0) begin
					dec_phase = cbd_pkg::PH_CRLF;
					after_data(c);
				end else begin
					r.payload_valid = 1'b1;
					r.payload_byte = c;
					dec_left = dec_left - 32'd1;
					dec_total = dec_total + 32'd1;
					if (dec_left == 0) begin
						dec_phase = cbd_pkg::PH_CRLF;
					end
				end
			end
			cbd_pkg::PH_CRLF: begin
				after_data(c);
			end
			cbd_pkg::PH_TRAILER: begin
				if (c == cbd_pkg::CH_LF) begin
					if (!dec_trailer_text) begin
						dec_phase = cbd_pkg::PH_DONE;
					end
					dec_trailer_text = 1'b0;
				end else if (c != cbd_pkg::CH_CR) begin
					dec_trailer_text = 1'b1;
				end
			end
			default: begin
				r.consumed = 1'b0;
			end
		endcase
		r.phase = dec_phase;
		r.chunk_left = dec_left;
		r.body_total = dec_total;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 20) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	// Each result beat against the oldest prediction
	always @(posedge clk) begin
		cbd_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				report_error("result beat with no byte outstanding");
			end else begin
				want = expected_q.pop_front();
				check_field("consumed", 32'(consumed), 32'(want.consumed));
				check_field("payload_valid", 32'(payload_valid), 32'(want.payload_valid));
				check_field("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
				check_field("phase", 32'(phase), 32'(want.phase));
				check_field("chunk_left", chunk_left, want.chunk_left);
				check_field("body_total", body_total, want.body_total);
			end
		end
	end

	// Random result side back-pressure bursts, started only while idle_on is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------

	// Called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(input logic [7:0] b, input logic start);
		cbd_pkg::result_t r;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		body_start <= start;
		@(posedge clk);
		while (data_stall) @(posedge clk);
		r = decode_byte(b, start);
		expected_q.push_back(r);
		if (r.consumed) begin
			taken_bytes++;
			if (r.payload_valid) begin
				payload_seen++;
			end
			if (r.phase == cbd_pkg::PH_DONE) begin
				bodies_done++;
			end
			if (r.phase == cbd_pkg::PH_ERROR) begin
				bodies_failed++;
			end
		end
		@(negedge clk);
	endtask

	task automatic send_body();
		foreach (pend_q[i]) begin
			send_beat(pend_q[i], i == 0);
		end
		bodies_sent++;
	endtask

	// Hold the input off until every outstanding result is back
	task automatic drain_results();
		data_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Body generation
	// ---------------------------------------------------------------

	// Random bytes that never end the line
	function automatic void add_junk(input int n);
		logic [7:0] ch;
		repeat (n) begin
			ch = 8'($urandom_range(0, 255));
			pend_q.push_back((ch == cbd_pkg::CH_LF) ? cbd_pkg::CH_SEMI : ch);
		end
	endfunction

	function automatic void add_line_end();
		case ($urandom_range(0, 7))
			0: begin
				pend_q.push_back(cbd_pkg::CH_LF);
			end
			1: begin
				pend_q.push_back(cbd_pkg::CH_CR);
				pend_q.push_back(cbd_pkg::CH_CR);
				pend_q.push_back(cbd_pkg::CH_LF);
			end
			default: begin
				pend_q.push_back(cbd_pkg::CH_CR);
				pend_q.push_back(cbd_pkg::CH_LF);
			end
		endcase
	endfunction

	// Minimal hex digits, mixed case
	function automatic void add_hex(input logic [31:0] v);
		int n;
		logic [3:0] nib;
		logic [7:0] ch;
		n = 8;
		while (n > 1 && v[4*n-1 -: 4] == 4'd0) n--;
		for (int i = n - 1; i >= 0; i--) begin
			nib = v[4*i +: 4];
			if (nib < 4'd10) begin
				ch = 8'h30 + 8'(nib);
			end else if ($urandom_range(0, 1) == 1) begin
				ch = 8'h61 + 8'(nib) - 8'd10;
			end else begin
				ch = 8'h41 + 8'(nib) - 8'd10;
			end
			pend_q.push_back(ch);
		end
	endfunction

	// Size line: optional leading zeros, digits, optional ';' or NUL tail
	function automatic void add_size_line(input logic [31:0] v);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) pend_q.push_back("0");
		end
		add_hex(v);
		case ($urandom_range(0, 5))
			0: begin
				pend_q.push_back(cbd_pkg::CH_SEMI);
				add_junk($urandom_range(0, 5));
			end
			1: begin
				pend_q.push_back(cbd_pkg::CH_NUL);
				add_junk($urandom_range(0, 3));
			end
			default: ;
		endcase
		add_line_end();
	endfunction

	// Mostly well-formed bodies with random content; some get broken
	function automatic void build_body();
		flaw_e flaw;
		int len;
		int keep;
		flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : flaw_e'($urandom_range(1, 6));
		pend_q.delete();
		case (flaw)
			FLAW_NINE: begin
				pend_q.push_back("1");
				add_hex($urandom | 32'h1000_0000);
				add_line_end();
			end
			FLAW_LONG: begin
				// size line right around the line length limit
				len = $urandom_range(LINE_LEN - 3, LINE_LEN + 2);
				repeat (len - 1) pend_q.push_back("0");
				pend_q.push_back("1");
				add_line_end();
				pend_q.push_back(8'($urandom_range(0, 255)));
				add_line_end();
			end
			FLAW_HUGE: begin
				// big chunk that never completes
				add_size_line($urandom | 32'h1000_0000);
				repeat ($urandom_range(1, 8)) pend_q.push_back(8'($urandom_range(0, 255)));
				return;
			end
			FLAW_NODIGIT: begin
				if ($urandom_range(0, 1) == 1) begin
					pend_q.push_back(cbd_pkg::CH_SEMI);
					add_junk($urandom_range(0, 3));
				end
				add_line_end();
			end
			default: ;
		endcase
		repeat ($urandom_range(0, 3)) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			add_size_line(32'(len));
			repeat (len) pend_q.push_back(8'($urandom_range(0, 255)));
			add_line_end();
		end
		add_size_line(32'h0);
		repeat ($urandom_range(0, 2)) begin
			repeat ($urandom_range(1, 6)) pend_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
			add_line_end();
		end
		add_line_end();
		// bytes past the end are refused
		repeat ($urandom_range(0, 2)) pend_q.push_back(8'($urandom_range(0, 255)));
		if (flaw == FLAW_FLIP) begin
			pend_q[$urandom_range(0, pend_q.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (flaw == FLAW_CUT) begin
			keep = $urandom_range(1, pend_q.size() - 1);
			while (pend_q.size() > keep) void'(pend_q.pop_back());
		end
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Extension, NUL end, extreme payload bytes, trailer, done and error holds,
	// bad digit, largest chunk size
	task automatic test_directed();
		pend_q = {"2", cbd_pkg::CH_SEMI, "x", cbd_pkg::CH_CR, cbd_pkg::CH_LF, 8'h00, 8'hff,
			cbd_pkg::CH_CR, cbd_pkg::CH_LF, "0", cbd_pkg::CH_NUL, cbd_pkg::CH_LF, "T",
			cbd_pkg::CH_LF, cbd_pkg::CH_LF, "!"};
		send_body();
		pend_q = {"g", cbd_pkg::CH_LF, "?"};
		send_body();
		pend_q = {"F", "F", "F", "F", "f", "f", "f", "f", cbd_pkg::CH_LF};
		send_body();
		drain_results();
	endtask

	task automatic test_random_bodies(input int n_bytes);
		int stop_at;
		stop_at = taken_bytes + n_bytes;
		while (taken_bytes < stop_at) begin
			build_body();
			send_body();
		end
	endtask

	// Raw random bytes with an occasional restart flag
	task automatic test_noise(input int n_beats);
		repeat (n_beats) begin
			send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = 8'h00;
		body_start = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		idle_on = 1'b1;
		test_random_bodies(950);
		drain_results();
		test_noise(150);
		// last stretch runs flat out on both sides
		idle_on = 1'b0;
		test_random_bodies(200);

		drain_results();
		$display("Sent %0d bodies, %0d bytes taken, %0d payload bytes delivered",
			bodies_sent, taken_bytes, payload_seen);
		$display("%0d bodies decoded to the end, %0d stopped on a decode error",
			bodies_done, bodies_failed);
		if (errors == 0) begin
			$display("chunked_body_decoder verification clean");
		end else begin
			$display("chunked_body_decoder verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("chunked_body_decoder verification failed");
		$finish;
	end

endmodule

### filelist.f
src/cbd_pkg.sv
src/cbd_step.sv
src/chunked_body_decoder.sv
src/cbd_checker.sv
tb/sv/tb.sv
